>>> rtl/assert_macros.svh
// Concurrent assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/cctc_pkg.sv
`timescale 1ns / 1ps

package cctc_pkg;

    localparam int CodeW   = 4;
    localparam int LenW    = 28;
    localparam int DistW   = 16;
    localparam int StatW   = 2;
    localparam int CfgIdxW = 1;

    localparam logic [CodeW-1:0] OP_SOFT = 4'd4;
    localparam logic [CodeW-1:0] OP_HARD = 4'd5;

    localparam logic [StatW-1:0] STAT_OK       = 2'd0;
    localparam logic [StatW-1:0] STAT_NO_SEQ   = 2'd1;
    localparam logic [StatW-1:0] STAT_BAD_CLIP = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_DIST_FIVE  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DIST_THREE = 1'b1;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic [LenW-1:0]  len;
        logic             final_op;
        logic [LenW-1:0]  pos;
        logic [LenW-1:0]  rlen;
        logic             rev;
    } item_t;

    typedef struct packed {
        logic             trimmed;
        logic [StatW-1:0] status;
        logic [LenW-1:0]  start;
        logic [LenW-1:0]  stop;
    } result_t;

    function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                                input logic [LenW-1:0] b);
        logic [LenW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LenW] ? {LenW{1'b1}} : s[LenW-1:0];
    endfunction

endpackage

>>> rtl/cigar_clip_trim_check.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel  | Handshake            | Beat
// ---------+----------------------+--------------------------------------------------
// in       | in_valid / in_ready  | cigar_code, cigar_length, final_op, site_position,
//          |                      | read_length, reverse_strand
// out      | out_valid / out_ready| trimmed, status, aligned_start, aligned_end
// cfg      | cfg_write            | cfg_index, cfg_data
//
// One beat per cycle sustained while no result is held by out_ready low.
// A result passes through the input register, the walker logic and the result register.
// Reset clears both distances to zero and returns the clip state to the start of a read.
// A final op waits in the input register only while a result is held by out_ready low.

module cigar_clip_trim_check
    import cctc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CodeW-1:0]   cigar_code,
    input  logic [LenW-1:0]    cigar_length,
    input  logic               final_op,
    input  logic [LenW-1:0]    site_position,
    input  logic [LenW-1:0]    read_length,
    input  logic               reverse_strand,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               trimmed,
    output logic [StatW-1:0]   status,
    output logic [LenW-1:0]    aligned_start,
    output logic [LenW-1:0]    aligned_end,
    input  logic               cfg_write,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [DistW-1:0]   cfg_data
);

    logic [DistW-1:0] dist_five_reg;
    logic [DistW-1:0] dist_three_reg;

    item_t   item_in;
    item_t   s1_item;
    logic    s1_valid;
    logic    advance;
    logic    load;
    logic    can_load;
    result_t res;
    result_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_five_reg  <= '0;
            dist_three_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIST_FIVE:  dist_five_reg  <= cfg_data;
                CFG_DIST_THREE: dist_three_reg <= cfg_data;
                default:        dist_five_reg  <= dist_five_reg;
            endcase
        end
    end

    assign item_in.code     = cigar_code;
    assign item_in.len      = cigar_length;
    assign item_in.final_op = final_op;
    assign item_in.pos      = site_position;
    assign item_in.rlen     = read_length;
    assign item_in.rev      = reverse_strand;

    assign advance = s1_valid && (!s1_item.final_op || can_load);
    assign load    = advance && s1_item.final_op;

    cctc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (s1_valid),
        .item_out   (s1_item)
    );

    cctc_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (s1_item),
        .advance    (advance),
        .dist_five  (dist_five_reg),
        .dist_three (dist_three_reg),
        .res        (res)
    );

    cctc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res_in    (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign trimmed       = res_out.trimmed;
    assign status        = res_out.status;
    assign aligned_start = res_out.start;
    assign aligned_end   = res_out.stop;

    `ASSERT_NEXT(a_load_shows, load, out_valid)
    `ASSERT_NOW(a_hold_only_on_full, s1_valid && !advance,
        s1_item.final_op && out_valid && !out_ready)

endmodule

>>> rtl/cctc_in_stage.sv
`timescale 1ns / 1ps

module cctc_in_stage
    import cctc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item_in,
    input  logic  advance,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

>>> rtl/cctc_walker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cctc_walker
    import cctc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            item,
    input  logic             advance,
    input  logic [DistW-1:0] dist_five,
    input  logic [DistW-1:0] dist_three,
    output result_t          res
);

    logic            lead_reg,       lead_next;
    logic [LenW-1:0] lead_sum_reg,   lead_sum_next;
    logic            lead_bad_reg,   lead_bad_next;
    logic [LenW-1:0] trail_sum_reg,  trail_sum_next;
    logic [LenW-1:0] hard_sum_reg,   hard_sum_next;
    logic            trail_hard_reg, trail_hard_next;

    logic            is_soft;
    logic            is_hard;
    logic [LenW-1:0] qe;
    logic [LenW-1:0] after_hard;
    logic [LenW:0]   five_lim;
    logic [LenW:0]   three_lim;
    logic [LenW:0]   pos_d5;
    logic [LenW:0]   pos_d3;
    logic            hit;

    assign is_soft = (item.code == OP_SOFT);
    assign is_hard = (item.code == OP_HARD);

    always_comb
    begin
        lead_next       = lead_reg;
        lead_sum_next   = lead_sum_reg;
        lead_bad_next   = lead_bad_reg;
        trail_sum_next  = trail_sum_reg;
        hard_sum_next   = hard_sum_reg;
        trail_hard_next = trail_hard_reg;

        if (lead_reg)
        begin
            if (is_hard)
            begin
                if (lead_sum_reg != '0 && lead_sum_reg != item.rlen)
                begin
                    lead_bad_next = 1'b1;
                end
            end
            else if (is_soft)
            begin
                lead_sum_next = sat_add(lead_sum_reg, item.len);
            end
            else
            begin
                lead_next = 1'b0;
            end
        end

        if (is_soft)
        begin
            trail_sum_next = sat_add(trail_sum_reg, item.len);
        end
        else if (is_hard)
        begin
            if (!trail_hard_reg)
            begin
                hard_sum_next   = trail_sum_reg;
                trail_hard_next = 1'b1;
            end
        end
        else
        begin
            trail_sum_next  = '0;
            hard_sum_next   = '0;
            trail_hard_next = 1'b0;
        end
    end

    assign qe         = (trail_sum_next > item.rlen) ? '0 : item.rlen - trail_sum_next;
    assign after_hard = trail_sum_next - hard_sum_next;

    // Start limits are exclusive, end limits inclusive.
    assign five_lim  = {1'b0, lead_sum_next} + (LenW+1)'(dist_five);
    assign three_lim = {1'b0, lead_sum_next} + (LenW+1)'(dist_three);
    assign pos_d5    = {1'b0, item.pos} + (LenW+1)'(dist_five);
    assign pos_d3    = {1'b0, item.pos} + (LenW+1)'(dist_three);

    always_comb
    begin
        if (!item.rev)
        begin
            hit = ({1'b0, item.pos} < five_lim) || ({1'b0, qe} <= pos_d3);
        end
        else
        begin
            hit = ({1'b0, qe} <= pos_d5) || ({1'b0, item.pos} < three_lim);
        end
    end

    always_comb
    begin
        res.start = lead_sum_next;
        res.stop  = qe;
        priority if (lead_bad_next)
        begin
            res.status = STAT_BAD_CLIP;
        end
        else if (item.rlen == '0)
        begin
            res.status = STAT_NO_SEQ;
        end
        else if (trail_hard_next && after_hard != '0 && after_hard != item.rlen)
        begin
            res.status = STAT_BAD_CLIP;
        end
        else
        begin
            res.status = STAT_OK;
        end
        res.trimmed = (res.status == STAT_OK) && hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg       <= 1'b1;
            lead_sum_reg   <= '0;
            lead_bad_reg   <= 1'b0;
            trail_sum_reg  <= '0;
            hard_sum_reg   <= '0;
            trail_hard_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (item.final_op)
            begin
                lead_reg       <= 1'b1;
                lead_sum_reg   <= '0;
                lead_bad_reg   <= 1'b0;
                trail_sum_reg  <= '0;
                hard_sum_reg   <= '0;
                trail_hard_reg <= 1'b0;
            end
            else
            begin
                lead_reg       <= lead_next;
                lead_sum_reg   <= lead_sum_next;
                lead_bad_reg   <= lead_bad_next;
                trail_sum_reg  <= trail_sum_next;
                hard_sum_reg   <= hard_sum_next;
                trail_hard_reg <= trail_hard_next;
            end
        end
    end

    `ASSERT_NEXT(a_read_clears, advance && item.final_op,
        lead_reg && lead_sum_reg == '0 && !lead_bad_reg && !trail_hard_reg)
    `ASSERT_NOW(a_err_not_trimmed, res.status != STAT_OK, !res.trimmed)
    `ASSERT_NOW(a_soft_before_hard, trail_hard_reg, hard_sum_reg <= trail_sum_reg)

endmodule

>>> rtl/cctc_out_stage.sv
`timescale 1ns / 1ps

module cctc_out_stage
    import cctc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule
